// ===== rtl/swuart_pkg.sv =====
// Shared types, constants and helpers for the single wire half duplex UART.
// No dependencies; imported by every module of the block except swuart_ram.
`timescale 1ns / 1ps
`default_nettype none

package swuart_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;
  localparam int BYTE_W     = 8;
  localparam int PERIOD_W   = 16;
  localparam int TICK_W     = 17;
  localparam int BITCNT_W   = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [BITCNT_W-1:0] DATA_BITS = 4'd8;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST   = 16'd16;
  localparam logic [PERIOD_W-1:0] FIRST_SAMPLE_RST = 16'd24;

  localparam logic [1:0] REG_BIT_PERIOD   = 2'd0;
  localparam logic [1:0] REG_FIRST_SAMPLE = 2'd1;
  localparam logic [1:0] REG_TWO_WIRE     = 2'd2;
  localparam logic [1:0] REG_FINISH_EARLY = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RX   = 3'd1,
    PH_PRE  = 3'd2,
    PH_TX   = 3'd3,
    PH_STOP = 3'd4
  } phase_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [PERIOD_W-1:0] first_sample_delay;
    logic                two_wire_mode;
    logic                finish_early;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } store_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] x);
    at_least_one = (x == '0) ? TICK_W'(1) : x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/swuart_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swuart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/swuart_cfg.sv =====
// APB-style configuration registers: bit period, first sample delay, mode bits.
// Depends on swuart_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swuart_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [swuart_pkg::ADDR_W-1:0] paddr,
  input  wire logic [swuart_pkg::DATA_W-1:0] pwdata,
  output logic      [swuart_pkg::DATA_W-1:0] prdata,
  output logic                              pready,
  output swuart_pkg::cfg_t                  cfg
);
  import swuart_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period         <= BIT_PERIOD_RST;
      cfg.first_sample_delay <= FIRST_SAMPLE_RST;
      cfg.two_wire_mode      <= 1'b0;
      cfg.finish_early       <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BIT_PERIOD:   cfg.bit_period         <= pwdata[PERIOD_W-1:0];
        REG_FIRST_SAMPLE: cfg.first_sample_delay <= pwdata[PERIOD_W-1:0];
        REG_TWO_WIRE:     cfg.two_wire_mode      <= pwdata[0];
        REG_FINISH_EARLY: cfg.finish_early       <= pwdata[0];
        default:          cfg.finish_early       <= cfg.finish_early;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIT_PERIOD:   prdata = DATA_W'(cfg.bit_period);
      REG_FIRST_SAMPLE: prdata = DATA_W'(cfg.first_sample_delay);
      REG_TWO_WIRE:     prdata = DATA_W'(cfg.two_wire_mode);
      REG_FINISH_EARLY: prdata = DATA_W'(cfg.finish_early);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/swuart_engine.sv =====
// Receive/transmit sequencer: start edge detect, bit timing, shift register.
// Depends on swuart_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swuart_engine (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         line_level,
  input  wire logic                         send_request,
  input  wire logic [swuart_pkg::BYTE_W-1:0] send_byte,
  input  swuart_pkg::cfg_t                  cfg,
  output logic                              drive_low_next,
  output logic                              busy_next,
  output swuart_pkg::store_t                store
);
  import swuart_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  logic [TICK_W-1:0]     tick;
  logic [TICK_W-1:0]     tick_next;
  logic [BITCNT_W-1:0]   bit_cnt;
  logic [BITCNT_W-1:0]   bit_cnt_next;
  logic [BYTE_W-1:0]     shift;
  logic [BYTE_W-1:0]     shift_next;
  logic                  prev_level;
  logic                  wait_first;
  logic                  wait_first_next;
  logic                  drive_low;

  logic                  falling;
  logic [TICK_W-1:0]     tick_dec;
  logic [TICK_W-1:0]     period_min1;
  logic [TICK_W-1:0]     double_min1;
  logic [TICK_W-1:0]     stop_min1;
  logic [BITCNT_W-1:0]   bit_inc;
  logic [BYTE_W-1:0]     rx_shift;
  logic                  rx_sample;

  assign falling     = prev_level && !line_level;
  assign tick_dec    = (tick == '0) ? '0 : tick - 1'b1;
  assign period_min1 = at_least_one(TICK_W'(cfg.bit_period));
  assign double_min1 = at_least_one({cfg.bit_period, 1'b0});
  assign stop_min1   = at_least_one(cfg.finish_early ? TICK_W'(cfg.bit_period[PERIOD_W-1:1])
                                                     : TICK_W'(cfg.bit_period));
  assign bit_inc     = bit_cnt + 1'b1;
  assign rx_shift    = {line_level, shift[BYTE_W-1:1]};
  assign rx_sample   = (tick <= TICK_W'(1));

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (falling) begin
          phase_next = PH_RX;
        end else if (send_request) begin
          phase_next = wait_first ? PH_PRE : PH_TX;
        end
      end
      PH_RX: begin
        if (rx_sample && bit_inc >= DATA_BITS) begin
          phase_next = PH_IDLE;
        end
      end
      PH_PRE: begin
        if (tick_dec == '0) begin
          phase_next = PH_TX;
        end
      end
      PH_TX: begin
        if (tick_dec == '0 && bit_cnt >= DATA_BITS) begin
          phase_next = PH_STOP;
        end
      end
      PH_STOP: begin
        if (tick_dec == '0) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    tick_next       = tick;
    bit_cnt_next    = bit_cnt;
    shift_next      = shift;
    wait_first_next = wait_first;
    drive_low_next  = drive_low;
    store           = '{valid: 1'b0, data: rx_shift};
    unique case (phase)
      PH_IDLE: begin
        if (falling) begin
          tick_next    = TICK_W'(cfg.first_sample_delay);
          bit_cnt_next = '0;
          shift_next   = '0;
        end else if (send_request) begin
          shift_next = send_byte;
          if (wait_first) begin
            wait_first_next = 1'b0;
            drive_low_next  = 1'b0;
            tick_next       = double_min1;
          end else begin
            drive_low_next = 1'b1;
            bit_cnt_next   = '0;
            tick_next      = period_min1;
          end
        end
      end
      PH_RX: begin
        if (rx_sample) begin
          shift_next   = rx_shift;
          bit_cnt_next = bit_inc;
          tick_next    = TICK_W'(cfg.bit_period);
          if (bit_inc >= DATA_BITS) begin
            store.valid     = 1'b1;
            wait_first_next = 1'b1;
            bit_cnt_next    = '0;
            tick_next       = '0;
          end
        end else begin
          tick_next = tick_dec;
        end
      end
      PH_PRE: begin
        tick_next = tick_dec;
        if (tick_dec == '0) begin
          drive_low_next = 1'b1;
          bit_cnt_next   = '0;
          tick_next      = period_min1;
        end
      end
      PH_TX: begin
        tick_next = tick_dec;
        if (tick_dec == '0) begin
          if (bit_cnt < DATA_BITS) begin
            drive_low_next = !shift[0];
            shift_next     = {1'b0, shift[BYTE_W-1:1]};
            bit_cnt_next   = bit_inc;
            tick_next      = period_min1;
          end else begin
            drive_low_next = 1'b0;
            tick_next      = stop_min1;
          end
        end
      end
      PH_STOP: begin
        tick_next = tick_dec;
        if (tick_dec == '0) begin
          bit_cnt_next = '0;
        end
      end
      default: begin
        drive_low_next = 1'b0;
        tick_next      = '0;
        bit_cnt_next   = '0;
      end
    endcase
  end

  assign busy_next = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick       <= '0;
      bit_cnt    <= '0;
      shift      <= '0;
      prev_level <= 1'b1;
      wait_first <= 1'b1;
      drive_low  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      tick       <= tick_next;
      bit_cnt    <= bit_cnt_next;
      shift      <= shift_next;
      prev_level <= line_level;
      wait_first <= wait_first_next;
      drive_low  <= drive_low_next;
    end
  end

  a_rx_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && store.valid |=> phase == PH_IDLE && wait_first)
    else $error("reception end did not return to idle");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    step && $past(1'b1) && phase == PH_RX && !$past(phase == PH_RX) |-> $past(step))
    else $error("reception entered without a transfer");

endmodule

`default_nettype wire

// ===== rtl/swuart_ring.sv =====
// Receive ring buffer: RAM, read/write indices, fill count, sticky drop flag.
// Depends on swuart_pkg and swuart_ram.
`timescale 1ns / 1ps
`default_nettype none

module swuart_ring (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  swuart_pkg::store_t                store,
  input  wire logic                         pop_request,
  input  wire logic                         overflow_ack,
  output logic      [swuart_pkg::BYTE_W-1:0] oldest_byte,
  output logic                              rx_not_empty,
  output logic      [5:0]                   rx_count,
  output logic                              overflow_flag
);
  import swuart_pkg::*;

  logic [IDX_W-1:0]  rd;
  logic [IDX_W-1:0]  rd_next;
  logic [IDX_W-1:0]  wr;
  logic [IDX_W-1:0]  wr_rep;
  logic [IDX_W-1:0]  wr_inc;
  logic              dropped;
  logic              dropped_rep;
  logic              full;
  logic              stored;
  logic              empty_before;
  logic              we;
  logic [BYTE_W-1:0] ram_q;
  logic [BYTE_W-1:0] head;
  logic              fwd_valid;
  logic [BYTE_W-1:0] fwd_data;
  logic [CNT_W-1:0]  cnt;

  assign wr_inc       = next_idx(wr);
  assign full         = (wr_inc == rd);
  assign stored       = store.valid && !full;
  assign we           = step && stored;
  assign wr_rep       = stored ? wr_inc : wr;
  assign empty_before = (rd == wr);
  assign rx_not_empty = (rd != wr_rep);
  assign dropped_rep  = dropped || (store.valid && full);
  assign head         = fwd_valid ? fwd_data : ram_q;

  assign oldest_byte   = !rx_not_empty ? '0 : (empty_before ? store.data : head);
  assign overflow_flag = dropped_rep;

  assign cnt = (wr_rep >= rd) ? CNT_W'(wr_rep) - CNT_W'(rd)
                              : CNT_W'(wr_rep) + CNT_W'(RING_DEPTH) - CNT_W'(rd);
  assign rx_count = cnt[5:0];

  assign rd_next = (step && pop_request && rx_not_empty) ? next_idx(rd) : rd;

  swuart_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr),
    .wdata (store.data),
    .raddr (rd_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    fwd_data <= store.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd        <= '0;
      wr        <= '0;
      dropped   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      rd        <= rd_next;
      fwd_valid <= we && (wr == rd_next);
      if (step) begin
        wr      <= wr_rep;
        dropped <= dropped_rep && !overflow_ack;
      end
    end
  end

  a_drop_sets_flag: assert property (@(posedge clk) disable iff (rst)
    step && store.valid && full && !overflow_ack |=> dropped)
    else $error("dropped byte did not set overflow flag");

  a_idle_holds_indices: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(rd) && $stable(wr))
    else $error("ring indices moved without a transfer");

  a_pop_advances: assert property (@(posedge clk) disable iff (rst)
    step && pop_request && rx_not_empty |=> rd != $past(rd))
    else $error("pop did not advance read index");

endmodule

`default_nettype wire

// ===== rtl/single_wire_half_duplex_uart_top.sv =====
// Top level of the single wire half duplex UART: input and result registers,
// handshakes, configuration port. Depends on swuart_pkg, swuart_cfg,
// swuart_engine, swuart_ring.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   line_level, send_request, send_byte,
//                                             pop_request, overflow_ack
//   out      from block out_valid / out_stall wire_pull_low, tx_pin_level,
//                                             oldest_byte, rx_not_empty, rx_count,
//                                             overflow_flag, busy_res
//   apb      to block   psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// One transfer per clock sustained while the result side does not stall.
// The single pass from the input register to the result register sets the rate;
// the ring RAM read port is addressed with the next read index, with write forwarding.
// Reset is synchronous; the ring is empty at once, with no clearing pass.
// A stall on the result side holds the result register and then the input register.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_half_duplex_uart_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         line_level,
  input  wire logic                         send_request,
  input  wire logic [swuart_pkg::BYTE_W-1:0] send_byte,
  input  wire logic                         pop_request,
  input  wire logic                         overflow_ack,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              wire_pull_low,
  output logic                              tx_pin_level,
  output logic      [swuart_pkg::BYTE_W-1:0] oldest_byte,
  output logic                              rx_not_empty,
  output logic      [5:0]                   rx_count,
  output logic                              overflow_flag,
  output logic                              busy_res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [swuart_pkg::ADDR_W-1:0] paddr,
  input  wire logic [swuart_pkg::DATA_W-1:0] pwdata,
  output logic      [swuart_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);
  import swuart_pkg::*;

  cfg_t              cfg;
  store_t            store;
  logic              item_valid;
  logic              item_line;
  logic              item_sreq;
  logic [BYTE_W-1:0] item_byte;
  logic              item_pop;
  logic              item_ack;
  logic              step;
  logic              accept;
  logic              drive_low_next;
  logic              busy_next;
  logic [BYTE_W-1:0] ring_oldest;
  logic              ring_not_empty;
  logic [5:0]        ring_count;
  logic              ring_overflow;

  assign step     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !step;
  assign accept   = in_valid && !in_stall;

  swuart_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swuart_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .line_level     (item_line),
    .send_request   (item_sreq),
    .send_byte      (item_byte),
    .cfg            (cfg),
    .drive_low_next (drive_low_next),
    .busy_next      (busy_next),
    .store          (store)
  );

  swuart_ring u_ring (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .store         (store),
    .pop_request   (item_pop),
    .overflow_ack  (item_ack),
    .oldest_byte   (ring_oldest),
    .rx_not_empty  (ring_not_empty),
    .rx_count      (ring_count),
    .overflow_flag (ring_overflow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_line <= line_level;
      item_sreq <= send_request;
      item_byte <= send_byte;
      item_pop  <= pop_request;
      item_ack  <= overflow_ack;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      wire_pull_low <= !cfg.two_wire_mode && drive_low_next;
      tx_pin_level  <= !(cfg.two_wire_mode && drive_low_next);
      oldest_byte   <= ring_oldest;
      rx_not_empty  <= ring_not_empty;
      rx_count      <= ring_count;
      overflow_flag <= ring_overflow;
      busy_res      <= busy_next;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_single_wire_half_duplex_uart_top.sv =====
// Self-checking testbench for single_wire_half_duplex_uart_top: drives timer ticks
// carrying line levels, send, pop and acknowledge requests, and checks every report.
// Depends on swuart_pkg and the block's RTL; its own line model predicts each report.
`timescale 1ns / 1ps

module tb_single_wire_half_duplex_uart_top;
  import swuart_pkg::*;

  localparam int IDLE_A         = 35;
  localparam int IDLE_B         = 45;
  localparam int ACK_PCT        = 4;
  localparam int SEND_NOISE_PCT = 3;
  localparam int DRAIN_SLACK    = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic        wire_pull_low;
    logic        tx_pin_level;
    logic [7:0]  oldest_byte;
    logic        rx_not_empty;
    logic [5:0]  rx_count;
    logic        overflow_flag;
    logic        busy_res;
  } line_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        line_level = 1'b1;
  logic        send_request = 1'b0;
  logic [7:0]  send_byte = 8'h00;
  logic        pop_request = 1'b0;
  logic        overflow_ack = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        wire_pull_low;
  logic        tx_pin_level;
  logic [7:0]  oldest_byte;
  logic        rx_not_empty;
  logic [5:0]  rx_count;
  logic        overflow_flag;
  logic        busy_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  single_wire_half_duplex_uart_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .line_level(line_level), .send_request(send_request), .send_byte(send_byte),
    .pop_request(pop_request), .overflow_ack(overflow_ack),
    .out_valid(out_valid), .out_stall(out_stall),
    .wire_pull_low(wire_pull_low), .tx_pin_level(tx_pin_level),
    .oldest_byte(oldest_byte), .rx_not_empty(rx_not_empty), .rx_count(rx_count),
    .overflow_flag(overflow_flag), .busy_res(busy_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // line model state
  logic [15:0] m_bp = BIT_PERIOD_RST;
  logic [15:0] m_fsd = FIRST_SAMPLE_RST;
  logic        m_two_wire = 1'b0;
  logic        m_early = 1'b0;
  logic [7:0]  rx_ring [RING_DEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  logic        dropped = 1'b0;
  logic        pre_wait = 1'b1;
  phase_t      eng_phase = PH_IDLE;
  int unsigned ticks = 0;
  logic [3:0]  nbits = '0;
  logic [7:0]  shreg = '0;
  logic        prev_lvl = 1'b1;
  logic        pulling = 1'b0;

  line_report_t pending_reports[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          sender_gap_pct = 0;
  int          receiver_stall_pct = 0;
  int          pop_rate = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned min_one(int unsigned x);
    return (x == 0) ? 1 : x;
  endfunction

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= RING_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic string show(line_report_t r);
    return $sformatf("pull=%b tx=%b byte=%h ne=%b cnt=%0d ovf=%b busy=%b",
                     r.wire_pull_low, r.tx_pin_level, r.oldest_byte, r.rx_not_empty,
                     r.rx_count, r.overflow_flag, r.busy_res);
  endfunction

  task automatic launch_frame();
    eng_phase = PH_TX;
    pulling = 1'b1;
    nbits = '0;
    ticks = min_one(m_bp);
  endtask

  task automatic advance_serial_model(input logic lvl, req, input logic [7:0] data,
                                      input logic pop, ack, output line_report_t rep);
    logic        falling;
    logic        nonempty;
    int unsigned nxt;
    falling = prev_lvl && !lvl;
    case (eng_phase)
      PH_IDLE: begin
        if (falling) begin
          eng_phase = PH_RX;
          ticks = m_fsd;
          nbits = '0;
          shreg = '0;
        end else if (req) begin
          shreg = data;
          if (pre_wait) begin
            pre_wait = 1'b0;
            eng_phase = PH_PRE;
            pulling = 1'b0;
            ticks = min_one({m_bp, 1'b0});
          end else begin
            launch_frame();
          end
        end
      end
      PH_RX: begin
        if (ticks <= 1) begin
          shreg = {lvl, shreg[7:1]};
          nbits = nbits + 1'b1;
          ticks = m_bp;
          if (nbits >= DATA_BITS) begin
            nxt = ring_next(wr_ptr);
            if (nxt == rd_ptr) begin
              dropped = 1'b1;
            end else begin
              rx_ring[wr_ptr] = shreg;
              wr_ptr = nxt;
            end
            pre_wait = 1'b1;
            eng_phase = PH_IDLE;
            nbits = '0;
            ticks = 0;
          end
        end else begin
          ticks = ticks - 1;
        end
      end
      PH_PRE: begin
        ticks = (ticks != 0) ? ticks - 1 : 0;
        if (ticks == 0) launch_frame();
      end
      PH_TX: begin
        ticks = (ticks != 0) ? ticks - 1 : 0;
        if (ticks == 0) begin
          if (nbits < DATA_BITS) begin
            pulling = !shreg[0];
            shreg = shreg >> 1;
            nbits = nbits + 1'b1;
            ticks = min_one(m_bp);
          end else begin
            pulling = 1'b0;
            eng_phase = PH_STOP;
            ticks = min_one(m_early ? (m_bp >> 1) : m_bp);
          end
        end
      end
      PH_STOP: begin
        ticks = (ticks != 0) ? ticks - 1 : 0;
        if (ticks == 0) begin
          eng_phase = PH_IDLE;
          nbits = '0;
        end
      end
      default: begin
        eng_phase = PH_IDLE;
        pulling = 1'b0;
        ticks = 0;
        nbits = '0;
      end
    endcase
    prev_lvl = lvl;

    nonempty = (rd_ptr != wr_ptr);
    rep.wire_pull_low = !m_two_wire && pulling;
    rep.tx_pin_level = !(m_two_wire && pulling);
    rep.oldest_byte = nonempty ? rx_ring[rd_ptr] : 8'h00;
    rep.rx_not_empty = nonempty;
    rep.rx_count = 6'((wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH);
    rep.overflow_flag = dropped;
    rep.busy_res = (eng_phase != PH_IDLE);

    if (pop && nonempty) rd_ptr = ring_next(rd_ptr);
    if (ack) dropped = 1'b0;
  endtask

  task automatic send_tick(input logic lvl, req, input logic [7:0] data,
                           input logic pop, ack);
    line_report_t rep;
    while (chance(sender_gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    line_level <= lvl;
    send_request <= req;
    send_byte <= data;
    pop_request <= pop;
    overflow_ack <= ack;
    do @(posedge clk); while (in_stall);
    advance_serial_model(lvl, req, data, pop, ack, rep);
    pending_reports.push_back(rep);
    items_sent++;
  endtask

  task automatic quiet_tick();
    send_tick(1'b1, 1'b0, 8'($urandom), chance(pop_rate), chance(ACK_PCT));
  endtask

  // start bit, then each data bit held across the tick on which it is sampled
  task automatic send_frame(input logic [7:0] data, input bit req_at_edge);
    int   s0, span, lead, j, k;
    logic lvl;
    s0 = min_one(m_fsd);
    span = min_one(m_bp);
    lead = s0 - span / 2;
    if (!prev_lvl) quiet_tick();
    for (j = 0; j <= s0 + 7 * span; j++) begin
      if (j == 0 || j < lead) begin
        lvl = 1'b0;
      end else begin
        k = (j - lead) / span;
        if (k > 7) k = 7;
        lvl = data[k];
      end
      send_tick(lvl, (j == 0 && req_at_edge) || chance(SEND_NOISE_PCT), 8'($urandom),
                chance(pop_rate), chance(ACK_PCT));
    end
    repeat (span) send_tick(1'b1, chance(SEND_NOISE_PCT), 8'($urandom),
                            chance(pop_rate), chance(ACK_PCT));
  endtask

  task automatic finish_engine();
    while (eng_phase != PH_IDLE) quiet_tick();
  endtask

  task automatic random_traffic(input int n, input int frame_pct, input bit quiet);
    int target, roll;
    target = items_sent + n;
    while (items_sent < target) begin
      roll = $urandom_range(99);
      if (quiet) begin
        quiet_tick();
      end else if (eng_phase != PH_IDLE) begin
        send_tick(chance(90), chance(SEND_NOISE_PCT), 8'($urandom), chance(pop_rate),
                  chance(ACK_PCT));
      end else if (roll < frame_pct) begin
        send_frame(8'($urandom), chance(5));
      end else if (roll < frame_pct + (100 - frame_pct) / 2) begin
        send_tick(1'b1, 1'b1, 8'($urandom), chance(pop_rate), chance(ACK_PCT));
      end else begin
        repeat ($urandom_range(1, 4))
          send_tick(1'($urandom), chance(20), 8'($urandom), chance(pop_rate),
                    chance(ACK_PCT));
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BIT_PERIOD:   m_bp = value;
      REG_FIRST_SAMPLE: m_fsd = value;
      REG_TWO_WIRE:     m_two_wire = value[0];
      REG_FINISH_EARLY: m_early = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] bp, fsd, input logic tw, fe);
    drain_results();
    write_reg(REG_BIT_PERIOD, bp);
    write_reg(REG_FIRST_SAMPLE, fsd);
    write_reg(REG_TWO_WIRE, {15'd0, tw});
    write_reg(REG_FINISH_EARLY, {15'd0, fe});
  endtask

  task automatic test_reset_defaults();
    sender_gap_pct = IDLE_A;
    receiver_stall_pct = IDLE_B;
    pop_rate = 30;
    random_traffic(120, 70, 1'b0);
  endtask

  task automatic test_directed_corners();
    apply_settings(16'd1, 16'd1, 1'b0, 1'b0);
    pop_rate = 0;
    send_tick(1'b1, 1'b0, 8'hFF, 1'b1, 1'b1);
    send_frame(8'hFF, 1'b1);
    send_tick(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
    finish_engine();
    send_tick(1'b1, 1'b1, 8'hA5, 1'b0, 1'b0);
    finish_engine();
    send_frame(8'h00, 1'b0);
    send_tick(1'b1, 1'b0, 8'h5A, 1'b1, 1'b1);
  endtask

  task automatic test_ring_overflow();
    apply_settings(16'd1, 16'd2, 1'b0, 1'b1);
    pop_rate = 0;
    random_traffic(800, 95, 1'b0);
    pop_rate = 70;
    random_traffic(100, 60, 1'b0);
  endtask

  task automatic test_two_wire_half_stop();
    sender_gap_pct = IDLE_B;
    receiver_stall_pct = IDLE_A;
    apply_settings(16'd2, 16'd3, 1'b1, 1'b1);
    pop_rate = 40;
    random_traffic(150, 60, 1'b0);
  endtask

  task automatic test_open_drain_odd_period();
    apply_settings(16'd3, 16'd5, 1'b0, 1'b1);
    pop_rate = 30;
    random_traffic(100, 60, 1'b0);
  endtask

  task automatic test_zero_delays();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    apply_settings(16'd0, 16'd0, 1'b1, 1'b0);
    pop_rate = 20;
    random_traffic(80, 60, 1'b0);
  endtask

  task automatic test_extreme_periods();
    apply_settings(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    pop_rate = 50;
    random_traffic(40, 0, 1'b1);
  endtask

  always @(posedge clk) begin
    line_report_t seen, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= chance(receiver_stall_pct);
      if (out_valid && !out_stall) begin
        seen = '{wire_pull_low, tx_pin_level, oldest_byte, rx_not_empty, rx_count,
                 overflow_flag, busy_res};
        if (pending_reports.size() == 0) begin
          if (mismatches < 10) $display("unexpected report: %s", show(seen));
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (seen !== want) begin
            if (mismatches < 10)
              $display("report mismatch: expected %s, got %s", show(want), show(seen));
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_corners();
    test_ring_overflow();
    test_two_wire_half_stop();
    test_open_drain_odd_period();
    test_zero_delays();
    test_extreme_periods();
    drain_results();
    mismatches += pending_reports.size();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== single_wire_half_duplex_uart_top.f =====
rtl/swuart_pkg.sv
rtl/swuart_ram.sv
rtl/swuart_cfg.sv
rtl/swuart_engine.sv
rtl/swuart_ring.sv
rtl/single_wire_half_duplex_uart_top.sv
sim/tb_single_wire_half_duplex_uart_top.sv
